[rtl/fnvht_pkg.sv]
// Shared constants for the FNV-1a route hash table.
// No dependencies; used by the top level.
`default_nettype none
package fnvht_pkg;
  localparam int TABLE_DEPTH_DEF = 32;
  localparam int MAX_KEYS_DEF    = 16;
  localparam int TS_W            = 6;

  localparam logic [31:0] FNV_BASIS = 32'd2166136261;
  localparam logic [31:0] FNV_PRIME = 32'd16777619;

  localparam logic [1:0] KIND_INSERT = 2'd0;
  localparam logic [1:0] KIND_LOOKUP = 2'd1;
  localparam logic [1:0] KIND_CLEAR  = 2'd2;

  localparam logic [1:0] ST_INSERTED  = 2'd0;
  localparam logic [1:0] ST_FOUND     = 2'd1;
  localparam logic [1:0] ST_NOT_FOUND = 2'd2;
  localparam logic [1:0] ST_FULL      = 2'd3;
endpackage
`default_nettype wire

[rtl/fnvht_if.sv]
// Valid/ready channels for key bytes in and result words out.
// No dependencies.
`default_nettype none
interface fnvht_req_if;
  logic       valid;
  logic       ready;
  logic [1:0] kind;
  logic [7:0] key_byte;
  logic       last_byte;
  logic [3:0] route_id;
  modport source (output valid, kind, key_byte, last_byte, route_id, input ready);
  modport sink   (input valid, kind, key_byte, last_byte, route_id, output ready);
endinterface

interface fnvht_rsp_if;
  logic        valid;
  logic        ready;
  logic [1:0]  status;
  logic [4:0]  slot;
  logic [3:0]  found_route;
  logic [31:0] key_hash;
  logic [4:0]  probe_offset;
  modport source (output valid, status, slot, found_route, key_hash, probe_offset,
                  input ready);
  modport sink   (input valid, status, slot, found_route, key_hash, probe_offset,
                  output ready);
endinterface
`default_nettype wire

[rtl/fnvht_ram.sv]
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
`default_nettype none
module fnvht_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16,
  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  wire logic             clk,
  input  wire logic             we,
  input  wire logic [AW-1:0]    waddr,
  input  wire logic [WIDTH-1:0] wdata,
  input  wire logic [AW-1:0]    raddr,
  output logic      [WIDTH-1:0] rdata
);
  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end
endmodule
`default_nettype wire

[rtl/fnvht_top.sv]
// FNV-1a keyed route table with linear probing: top level.
// Depends on fnvht_pkg, fnvht_if and fnvht_ram.
//
// Each byte that is not last is folded into the hash (one 32x32 multiply) and
// the block stays ready. A last byte of an insert or lookup scans the key store,
// one entry a cycle, then runs a bit-serial modulo by the slot count (a lookup
// with no match, or an insert with no match and no free entry, ends after the
// scan). An insert then probes the slot RAM slot by slot; a lookup reads its
// slot once. After reset and after a clear the block sweeps both RAMs with ready
// low. Non-last bytes are accepted while a result word waits to be taken.
`default_nettype none
module fnv1a_linear_probe_hash_table_top
  import fnvht_pkg::*;
#(
  parameter int TABLE_DEPTH = TABLE_DEPTH_DEF,
  parameter int MAX_KEYS    = MAX_KEYS_DEF
) (
  input  wire logic            clk,
  input  wire logic            rst,
  input  wire logic            cfg_we,
  input  wire logic [TS_W-1:0] cfg_data,
  fnvht_req_if.sink            req,
  fnvht_rsp_if.source          rsp
);
  localparam int SW        = $clog2(TABLE_DEPTH);
  localparam int TSW       = $clog2(TABLE_DEPTH + 1);
  localparam int CW        = (TSW > TS_W) ? TSW : TS_W;
  localparam int KW        = (MAX_KEYS > 1) ? $clog2(MAX_KEYS) : 1;
  localparam int KCW       = $clog2(MAX_KEYS + 1);
  localparam int SWEEP_LEN = (TABLE_DEPTH > MAX_KEYS) ? TABLE_DEPTH : MAX_KEYS;
  localparam int SCW       = $clog2(SWEEP_LEN);
  localparam int STW       = 1 + 32 + SW;

  localparam logic [3:0] S_SWEEP    = 4'd0;
  localparam logic [3:0] S_IDLE     = 4'd1;
  localparam logic [3:0] S_SEARCH   = 4'd2;
  localparam logic [3:0] S_DIV      = 4'd3;
  localparam logic [3:0] S_PROBE_RD = 4'd4;
  localparam logic [3:0] S_PROBE_CK = 4'd5;
  localparam logic [3:0] S_LK_RD    = 4'd6;
  localparam logic [3:0] S_LK_CK    = 4'd7;
  localparam logic [3:0] S_DONE     = 4'd8;

  logic [3:0]      state;
  logic [TS_W-1:0] slot_count;
  logic [31:0]     acc;
  logic [31:0]     hreg;
  logic [1:0]      op;
  logic [3:0]      route;
  logic [SCW-1:0]  sweep_cnt;

  logic [KCW-1:0]  cnt;
  logic            rd_pend;
  logic [KW-1:0]   ev_idx;
  logic            match_found;
  logic [KW-1:0]   match_idx;
  logic [SW-1:0]   match_off;
  logic            free_found;
  logic [KW-1:0]   free_idx;

  logic [31:0]     dvd;
  logic [TSW-1:0]  rem;
  logic [5:0]      div_cnt;

  logic [SW-1:0]   s;
  logic [SW-1:0]   o;
  logic [31:0]     sum;

  logic [1:0]      res_status;
  logic [SW-1:0]   res_slot;
  logic [3:0]      res_route;
  logic [SW-1:0]   res_off;

  // effective table size, clamped to 1..TABLE_DEPTH
  logic [TSW-1:0]  ts_eff;
  always_comb begin
    if (slot_count == '0) begin
      ts_eff = TSW'(1);
    end else if (CW'(slot_count) > CW'(TABLE_DEPTH)) begin
      ts_eff = TSW'(TABLE_DEPTH);
    end else begin
      ts_eff = TSW'(slot_count);
    end
  end

  logic [31:0] mix;
  logic [31:0] h_comb;
  assign mix    = acc ^ {24'b0, req.key_byte};
  assign h_comb = mix * FNV_PRIME;

  assign req.ready = (state == S_IDLE);
  logic in_acc;
  assign in_acc = req.valid && req.ready;

  // divider step
  logic [TSW:0] dt;
  logic [TSW:0] dsub;
  logic [TSW-1:0] rem_step;
  assign dt       = {rem, dvd[31]};
  assign dsub     = dt - {1'b0, ts_eff};
  assign rem_step = (dt >= {1'b0, ts_eff}) ? dsub[TSW-1:0] : dt[TSW-1:0];

  // probe advance
  logic [TSW:0] s_inc;
  logic [TSW:0] o_inc;
  logic [31:0]  sum_next;
  assign s_inc    = (TSW + 1)'(s) + 1'b1;
  assign o_inc    = (TSW + 1)'(o) + 1'b1;
  assign sum_next = sum + 32'd1;

  // RAMs
  logic            sl_we;
  logic [SW-1:0]   sl_waddr;
  logic [4:0]      sl_wdata;
  logic [SW-1:0]   sl_raddr;
  logic [4:0]      sl_rdata;
  logic            st_we;
  logic [KW-1:0]   st_waddr;
  logic [STW-1:0]  st_wdata;
  logic [STW-1:0]  st_rdata;
  logic [KW-1:0]   entry;

  assign entry = match_found ? match_idx : free_idx;

  always_comb begin
    if (state == S_SWEEP) begin
      sl_we    = (SCW'(sweep_cnt) < SCW'(TABLE_DEPTH)) || (SWEEP_LEN == TABLE_DEPTH);
      sl_waddr = sweep_cnt[SW-1:0];
      sl_wdata = '0;
      st_we    = (sweep_cnt < SCW'(MAX_KEYS)) || (SWEEP_LEN == MAX_KEYS);
      st_waddr = sweep_cnt[KW-1:0];
      st_wdata = '0;
    end else begin
      sl_we    = (state == S_PROBE_CK) && !sl_rdata[4];
      sl_waddr = s;
      sl_wdata = {1'b1, route};
      st_we    = sl_we;
      st_waddr = entry;
      st_wdata = {1'b1, hreg, o};
    end
    sl_raddr = (state == S_LK_RD) ? rem[SW-1:0] : s;
  end

  fnvht_ram #(.WIDTH(5), .DEPTH(TABLE_DEPTH)) u_slot_ram (
    .clk(clk), .we(sl_we), .waddr(sl_waddr), .wdata(sl_wdata),
    .raddr(sl_raddr), .rdata(sl_rdata)
  );

  fnvht_ram #(.WIDTH(STW), .DEPTH(MAX_KEYS)) u_store_ram (
    .clk(clk), .we(st_we), .waddr(st_waddr), .wdata(st_wdata),
    .raddr(cnt[KW-1:0]), .rdata(st_rdata)
  );

  logic          e_valid;
  logic [31:0]   e_hash;
  assign e_valid = st_rdata[STW-1];
  assign e_hash  = st_rdata[SW+:32];

  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= S_SWEEP;
      slot_count <= TS_W'(32);
      acc        <= FNV_BASIS;
      sweep_cnt  <= '0;
      rsp.valid  <= 1'b0;
      rd_pend    <= 1'b0;
    end else begin
      if (cfg_we) begin
        slot_count <= cfg_data;
      end
      if (rsp.valid && rsp.ready && state != S_DONE) begin
        rsp.valid <= 1'b0;
      end
      case (state)
        S_SWEEP: begin
          if (sweep_cnt == SCW'(SWEEP_LEN - 1)) begin
            sweep_cnt <= '0;
            state     <= S_IDLE;
          end else begin
            sweep_cnt <= sweep_cnt + 1'b1;
          end
        end
        S_IDLE: begin
          if (in_acc) begin
            hreg  <= h_comb;
            op    <= req.kind;
            route <= req.route_id;
            if (!req.last_byte) begin
              acc <= h_comb;
            end else begin
              acc         <= FNV_BASIS;
              cnt         <= '0;
              rd_pend     <= 1'b0;
              match_found <= 1'b0;
              free_found  <= 1'b0;
              if (req.kind == KIND_INSERT || req.kind == KIND_LOOKUP) begin
                state <= S_SEARCH;
              end else if (req.kind == KIND_CLEAR) begin
                state <= S_SWEEP;
              end
            end
          end
        end
        S_SEARCH: begin
          // keep the first matching entry and the first free one
          if (rd_pend) begin
            if (e_valid && e_hash == hreg && !match_found) begin
              match_found <= 1'b1;
              match_idx   <= ev_idx;
              match_off   <= st_rdata[SW-1:0];
            end
            if (!e_valid && !free_found) begin
              free_found <= 1'b1;
              free_idx   <= ev_idx;
            end
          end
          if (cnt != KCW'(MAX_KEYS)) begin
            rd_pend <= 1'b1;
            ev_idx  <= cnt[KW-1:0];
            cnt     <= cnt + 1'b1;
          end else begin
            rd_pend <= 1'b0;
            if (!rd_pend) begin
              res_slot  <= '0;
              res_route <= '0;
              res_off   <= '0;
              rem       <= '0;
              div_cnt   <= '0;
              if (op == KIND_INSERT) begin
                if (!match_found && !free_found) begin
                  res_status <= ST_FULL;
                  state      <= S_DONE;
                end else begin
                  dvd   <= hreg;
                  state <= S_DIV;
                end
              end else if (!match_found) begin
                res_status <= ST_NOT_FOUND;
                state      <= S_DONE;
              end else begin
                dvd   <= hreg + 32'(match_off);
                state <= S_DIV;
              end
            end
          end
        end
        S_DIV: begin
          rem     <= rem_step;
          dvd     <= {dvd[30:0], 1'b0};
          div_cnt <= div_cnt + 1'b1;
          if (div_cnt == 6'd31) begin
            if (op == KIND_INSERT) begin
              s     <= rem_step[SW-1:0];
              o     <= '0;
              sum   <= hreg;
              state <= S_PROBE_RD;
            end else begin
              state <= S_LK_RD;
            end
          end
        end
        S_PROBE_RD: begin
          state <= S_PROBE_CK;
        end
        S_PROBE_CK: begin
          if (!sl_rdata[4]) begin
            res_status <= ST_INSERTED;
            res_slot   <= s;
            res_route  <= route;
            res_off    <= o;
            state      <= S_DONE;
          end else if (o_inc == {1'b0, ts_eff}) begin
            res_status <= ST_FULL;
            state      <= S_DONE;
          end else begin
            // the 32-bit sum wraps to zero, and the slot with it
            o   <= o_inc[SW-1:0];
            sum <= sum_next;
            if (sum_next == 32'd0 || s_inc == {1'b0, ts_eff}) begin
              s <= '0;
            end else begin
              s <= s_inc[SW-1:0];
            end
            state <= S_PROBE_RD;
          end
        end
        S_LK_RD: begin
          state <= S_LK_CK;
        end
        S_LK_CK: begin
          res_status <= ST_FOUND;
          res_slot   <= rem[SW-1:0];
          res_route  <= sl_rdata[3:0];
          res_off    <= match_off;
          state      <= S_DONE;
        end
        S_DONE: begin
          if (!rsp.valid || rsp.ready) begin
            rsp.valid        <= 1'b1;
            rsp.status       <= res_status;
            rsp.slot         <= 5'(res_slot);
            rsp.found_route  <= res_route;
            rsp.key_hash     <= hreg;
            rsp.probe_offset <= 5'(res_off);
            state            <= S_IDLE;
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

  a_ts_range: assert property (@(posedge clk) disable iff (rst)
    ts_eff != '0 && TSW'(ts_eff) <= TSW'(TABLE_DEPTH))
    else $error("effective table size out of range");

  a_rem_below_ts: assert property (@(posedge clk) disable iff (rst)
    (state == S_PROBE_RD || state == S_LK_RD) |-> rem < ts_eff || state == S_PROBE_RD)
    else $error("modulo result not below table size");

  a_probe_in_table: assert property (@(posedge clk) disable iff (rst)
    (state == S_PROBE_CK) |-> (TSW + 1)'(s) < {1'b0, ts_eff}
      && (TSW + 1)'(o) < {1'b0, ts_eff})
    else $error("probe left the table");

  a_sweep_after_reset: assert property (@(posedge clk) disable iff (rst)
    $past(rst) |-> !req.ready)
    else $error("ready during reset sweep");
endmodule
`default_nettype wire
